@@ sv/ilb_pkg.sv @@
// ----------------------------------------------------------------------------
// ilb_pkg: shared types and constants for the indexed list buffer
// Request and result layouts, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ilb_pkg;

  // Default list capacity in elements
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths of the request and result items
  localparam int KIND_W  = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 7;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_HEAD   = 3'd1,
    KIND_TAIL   = 3'd2,
    KIND_AT     = 3'd3,
    KIND_DELETE = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_PLACE,
    ST_RESP
  } state_t;

  // One request item
  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } req_t;

  // One result item
  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic                      found;
    status_t                   status;
    logic [LEN_W-1:0]          length;
  } result_t;

endpackage

@@ sv/ilb_if.sv @@
// ----------------------------------------------------------------------------
// ilb_if: item channels of the indexed list buffer
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel
interface ilb_in_if;
  logic                                valid;
  logic                                ready;
  logic [ilb_pkg::KIND_W-1:0]          kind;
  logic [ilb_pkg::POS_W-1:0]           position;
  logic signed [ilb_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, kind, position, item_value, input ready);
  modport sink   (input valid, kind, position, item_value, output ready);
endinterface

// Result channel
interface ilb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ilb_pkg::DATA_W-1:0]   read_value;
  logic                                found;
  logic [ilb_pkg::STAT_W-1:0]          status;
  logic [ilb_pkg::LEN_W-1:0]           length;

  modport source (output valid, read_value, found, status, length, input ready);
  modport sink   (input valid, read_value, found, status, length, output ready);
endinterface

@@ sv/ilb_ram.sv @@
// ----------------------------------------------------------------------------
// ilb_ram: element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ilb_ram #(
  parameter int DEPTH = ilb_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wen,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [ilb_pkg::DATA_W-1:0]  wdata,
  input  logic                               ren,
  input  logic [AW-1:0]                      raddr,
  output logic signed [ilb_pkg::DATA_W-1:0]  rdata
);

  logic signed [ilb_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ilb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ilb_ctrl: request sequencer of the indexed list buffer
// Checks each request against the element count, then walks the store one
// slot per move with a single step/compare index unit to open or close a gap.
// ----------------------------------------------------------------------------
module ilb_ctrl #(
  parameter int CAPACITY = ilb_pkg::CAPACITY_DEF,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request side
  input  logic                               req_valid,
  output logic                               req_ready,
  input  ilb_pkg::req_t                      req,
  // result side
  output logic                               res_valid,
  input  logic                               res_ready,
  output ilb_pkg::result_t                   res,
  // element store
  output logic                               ram_wen,
  output logic [IW-1:0]                      ram_waddr,
  output logic signed [ilb_pkg::DATA_W-1:0]  ram_wdata,
  output logic                               ram_ren,
  output logic [IW-1:0]                      ram_raddr,
  input  logic signed [ilb_pkg::DATA_W-1:0]  ram_rdata
);

  localparam int CMPW = (CW > ilb_pkg::POS_W) ? CW : ilb_pkg::POS_W;

  ilb_pkg::state_t                   state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic [IW-1:0]                     stop_r, stop_nxt;
  logic                              up_r, up_nxt;
  logic signed [ilb_pkg::DATA_W-1:0] value_r, value_nxt;
  ilb_pkg::status_t                  status_r, status_nxt;
  logic                              found_r, found_nxt;

  logic            accept;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] at_ext;
  logic            idx_ok;
  logic            ins_range;
  logic            ins_full;
  logic            ins_append;
  logic            del_last;
  logic [IW-1:0]   step;
  logic            step_hit;

  assign accept = req_valid && req_ready;

  // Request checks against the current count
  assign pos_ext = CMPW'(req.position);
  assign cnt_ext = CMPW'(count_r);

  always_comb begin
    case (req.kind)
      ilb_pkg::KIND_HEAD: at_ext = '0;
      ilb_pkg::KIND_TAIL: at_ext = cnt_ext;
      default:            at_ext = pos_ext;
    endcase
  end

  assign idx_ok     = pos_ext < cnt_ext;
  assign ins_range  = at_ext > cnt_ext;
  assign ins_full   = count_r == CW'(CAPACITY);
  assign ins_append = at_ext == cnt_ext;
  assign del_last   = pos_ext == (cnt_ext - CMPW'(1));

  // Shared index unit: one step toward the stop slot and the hit compare
  assign step     = up_r ? idx_r + IW'(1) : idx_r - IW'(1);
  assign step_hit = step == stop_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ilb_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.kind)
            ilb_pkg::KIND_HEAD, ilb_pkg::KIND_TAIL, ilb_pkg::KIND_AT: begin
              if (ins_range || ins_full) begin
                state_nxt = ilb_pkg::ST_RESP;
              end else if (ins_append) begin
                state_nxt = ilb_pkg::ST_PLACE;
              end else begin
                state_nxt = ilb_pkg::ST_RD;
              end
            end
            ilb_pkg::KIND_DELETE: begin
              if (!idx_ok || del_last) begin
                state_nxt = ilb_pkg::ST_RESP;
              end else begin
                state_nxt = ilb_pkg::ST_RD;
              end
            end
            default: state_nxt = ilb_pkg::ST_RESP;
          endcase
        end
      end
      ilb_pkg::ST_RD: state_nxt = ilb_pkg::ST_WR;
      ilb_pkg::ST_WR: begin
        if (!step_hit) begin
          state_nxt = ilb_pkg::ST_RD;
        end else if (up_r) begin
          state_nxt = ilb_pkg::ST_RESP;
        end else begin
          state_nxt = ilb_pkg::ST_PLACE;
        end
      end
      ilb_pkg::ST_PLACE: state_nxt = ilb_pkg::ST_RESP;
      ilb_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = ilb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ilb_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, store accesses and the result
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    ram_wen   = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_ren   = 1'b0;
    ram_raddr = step;
    case (state_r)
      ilb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        // fetch the addressed element of a read straight away
        if (accept && req.kind == ilb_pkg::KIND_READ && idx_ok) begin
          ram_ren   = 1'b1;
          ram_raddr = IW'(pos_ext);
        end
      end
      ilb_pkg::ST_RD: ram_ren = 1'b1;
      ilb_pkg::ST_WR: ram_wen = 1'b1;
      ilb_pkg::ST_PLACE: begin
        ram_wen   = 1'b1;
        ram_wdata = value_r;
      end
      ilb_pkg::ST_RESP: res_valid = 1'b1;
      default: ;
    endcase
    res.read_value = found_r ? ram_rdata : '0;
    res.found      = found_r;
    res.status     = status_r;
    res.length     = ilb_pkg::LEN_W'(count_r);
  end

  // Datapath next values
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    stop_nxt   = stop_r;
    up_nxt     = up_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    case (state_r)
      ilb_pkg::ST_IDLE: begin
        if (accept) begin
          status_nxt = ilb_pkg::STAT_DONE;
          found_nxt  = 1'b0;
          value_nxt  = req.item_value;
          case (req.kind)
            ilb_pkg::KIND_READ: begin
              if (idx_ok) begin
                found_nxt = 1'b1;
              end else begin
                status_nxt = ilb_pkg::STAT_RANGE;
              end
            end
            ilb_pkg::KIND_HEAD, ilb_pkg::KIND_TAIL, ilb_pkg::KIND_AT: begin
              // open the gap from the tail back toward the insert slot
              idx_nxt  = IW'(cnt_ext);
              stop_nxt = IW'(at_ext);
              up_nxt   = 1'b0;
              if (ins_range) begin
                status_nxt = ilb_pkg::STAT_RANGE;
              end else if (ins_full) begin
                status_nxt = ilb_pkg::STAT_FULL;
              end
            end
            ilb_pkg::KIND_DELETE: begin
              // close the gap from the deleted slot up to the last element
              idx_nxt  = IW'(pos_ext);
              stop_nxt = IW'(cnt_ext - CMPW'(1));
              up_nxt   = 1'b1;
              if (!idx_ok) begin
                status_nxt = ilb_pkg::STAT_RANGE;
              end else if (del_last) begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ilb_pkg::ST_WR: begin
        idx_nxt = step;
        if (step_hit && up_r) begin
          count_nxt = count_r - CW'(1);
        end
      end
      ilb_pkg::ST_PLACE: count_nxt = count_r + CW'(1);
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilb_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    stop_r   <= stop_nxt;
    up_r     <= up_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

endmodule

@@ sv/indexed_list_buffer.sv @@
// ----------------------------------------------------------------------------
// indexed_list_buffer: ordered list of signed 32-bit values
// Read, insert at head, tail or index, and delete at index, one result each.
// ----------------------------------------------------------------------------
// Each request gives one result item. Elements sit in a RAM with one read and
// one write port and are moved one slot per move, each a read then a write,
// by one shared index step unit; an insert then writes the new value into
// the opened slot. The request channel is taken again as soon as the result
// has moved into the output register, which holds it until taken.
// ----------------------------------------------------------------------------
module indexed_list_buffer #(
  parameter int CAPACITY = ilb_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilb_in_if.sink     in_ch,
  ilb_out_if.source  out_ch
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ilb_pkg::req_t                     req;
  ilb_pkg::result_t                  res;
  logic                              res_valid;
  logic                              res_ready;
  logic                              ram_wen;
  logic [IW-1:0]                     ram_waddr;
  logic signed [ilb_pkg::DATA_W-1:0] ram_wdata;
  logic                              ram_ren;
  logic [IW-1:0]                     ram_raddr;
  logic signed [ilb_pkg::DATA_W-1:0] ram_rdata;

  logic                              out_valid_r, out_valid_nxt;
  ilb_pkg::result_t                  out_data_r;

  // Gather the request fields
  assign req.kind       = ilb_pkg::kind_t'(in_ch.kind);
  assign req.position   = in_ch.position;
  assign req.item_value = in_ch.item_value;

  ilb_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_wen   (ram_wen),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_ren   (ram_ren),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ilb_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .ren   (ram_ren),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  // Drive the result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r.read_value;
  assign out_ch.found      = out_data_r.found;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.length     = out_data_r.length;

endmodule
